FILE: design/pes_pkg.sv
// shared types and constants of the predicated exact sum block
// no dependencies
package pes_pkg;

  localparam int unsigned ChunkRows = 4096;
  localparam int unsigned RowCntW   = $clog2(ChunkRows + 1);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW     = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW     = $clog2(QueueDepth + 1);

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 64;

  // register index is taken from address bit 3
  localparam logic RegCompareOp = 1'b0;
  localparam logic RegThreshold = 1'b1;

  typedef enum logic [2:0] {
    CmpLt  = 3'd0,
    CmpLe  = 3'd1,
    CmpGt  = 3'd2,
    CmpGe  = 3'd3,
    CmpEq  = 3'd4,
    CmpNe  = 3'd5,
    CmpAll = 3'd6
  } cmp_op_e;

  typedef struct packed {
    logic signed [63:0] value;
    logic signed [63:0] key;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] sum;
    logic               overflow;
  } out_item_t;

  // classified row between front and back
  typedef struct packed {
    logic signed [63:0] value;
    logic               selected;
    logic               out_of_bound;
    logic               last;
  } row_t;

  function automatic logic add_ovf(logic [63:0] a, logic [63:0] b, logic [63:0] r);
    return (a[63] == b[63]) && (r[63] != a[63]);
  endfunction

endpackage

FILE: design/pes_front.sv
// front end: configuration registers, row predicate and bound classification
// depends on pes_pkg
module pes_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pes_pkg::AddrW-1:0]  paddr,
  input  logic [pes_pkg::DataW-1:0]  pwdata,
  output logic [pes_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  input  pes_pkg::in_item_t          item_i,
  output pes_pkg::row_t              row_o
);

  logic [2:0]         op_q, op_d;
  logic signed [63:0] thr_q, thr_d;
  logic               wr_en;
  logic               lt, eq, sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    op_d  = op_q;
    thr_d = thr_q;
    if (wr_en) begin
      if (paddr[3] == pes_pkg::RegCompareOp) begin
        op_d = pwdata[2:0];
      end else begin
        thr_d = pwdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= pes_pkg::CmpAll;
      thr_q <= '0;
    end else begin
      op_q  <= op_d;
      thr_q <= thr_d;
    end
  end

  always_comb begin
    if (paddr[3] == pes_pkg::RegCompareOp) begin
      prdata = {{(pes_pkg::DataW-3){1'b0}}, op_q};
    end else begin
      prdata = thr_q;
    end
  end

  assign lt = item_i.key < thr_q;
  assign eq = item_i.key == thr_q;

  always_comb begin
    unique case (pes_pkg::cmp_op_e'(op_q))
      pes_pkg::CmpLt: sel = lt;
      pes_pkg::CmpLe: sel = lt || eq;
      pes_pkg::CmpGt: sel = !(lt || eq);
      pes_pkg::CmpGe: sel = !lt;
      pes_pkg::CmpEq: sel = eq;
      pes_pkg::CmpNe: sel = !eq;
      default:        sel = 1'b1;
    endcase
  end

  // in bound when bits 63..50 are all equal
  always_comb begin
    row_o.value        = item_i.value;
    row_o.selected     = sel;
    row_o.out_of_bound = !((&item_i.value[63:50]) || !(|item_i.value[63:50]));
    row_o.last         = item_i.last;
  end

endmodule

FILE: design/pes_queue.sv
// short queue of classified rows between front and back
// depends on pes_pkg
module pes_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pes_pkg::row_t push_row_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output pes_pkg::row_t head_o
);

  pes_pkg::row_t                mem_q [pes_pkg::QueueDepth];
  logic [pes_pkg::QPtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [pes_pkg::QCntW-1:0]    cnt_q, cnt_d;

  assign full_o  = cnt_q == pes_pkg::QCntW'(pes_pkg::QueueDepth);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == pes_pkg::QPtrW'(pes_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == pes_pkg::QPtrW'(pes_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_row_i;
    end
  end

endmodule

FILE: design/pes_back.sv
// back end: chunk accumulation, grand total stage and result register
// depends on pes_pkg
module pes_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              row_valid_i,
  input  pes_pkg::row_t     row_i,
  output logic              row_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pes_pkg::out_item_t out_item_o
);

  // chunk stage
  logic [63:0]                 wrap_q, wrap_d, chk_q, chk_d;
  logic                        oob_q, oob_d, caov_q, caov_d;
  logic [pes_pkg::RowCntW-1:0] cnt_q, cnt_d;
  logic [63:0]                 wrap_new, chk_new, chk_sum, addv;
  logic                        oob_new, caov_new, chk_ovf, closes;

  // close stage
  logic        cl_valid_q, cl_valid_d;
  logic [63:0] cl_part_q, cl_part_d;
  logic        cl_fail_q, cl_fail_d, cl_last_q, cl_last_d;
  logic        cl_free, cl_fire;

  // total stage
  logic [63:0] tot_q, tot_d, tot_sum;
  logic        failed_q, failed_d, fail_pre, tot_ovf, fail_new;
  logic [63:0] tot_new;

  // result register
  logic                 out_valid_q, out_valid_d;
  pes_pkg::out_item_t   out_q, out_d;
  logic                 out_free;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign cl_fire   = cl_valid_q && (!cl_last_q || out_free);
  assign cl_free   = !cl_valid_q || cl_fire;
  assign closes    = row_i.last || (cnt_q == pes_pkg::RowCntW'(pes_pkg::ChunkRows - 1));
  assign row_pop_o = row_valid_i && (!closes || cl_free);

  assign addv     = row_i.selected ? row_i.value : '0;
  assign wrap_new = wrap_q + addv;
  assign chk_sum  = chk_q + row_i.value;
  assign chk_ovf  = pes_pkg::add_ovf(chk_q, row_i.value, chk_sum);

  always_comb begin
    oob_new  = oob_q;
    caov_new = caov_q;
    chk_new  = chk_q;
    if (row_i.selected) begin
      oob_new = oob_q || row_i.out_of_bound;
      if (!caov_q) begin
        if (chk_ovf) begin
          caov_new = 1'b1;
        end else begin
          chk_new = chk_sum;
        end
      end
    end
  end

  always_comb begin
    wrap_d     = wrap_q;
    chk_d      = chk_q;
    oob_d      = oob_q;
    caov_d     = caov_q;
    cnt_d      = cnt_q;
    cl_valid_d = cl_valid_q && !cl_fire;
    cl_part_d  = cl_part_q;
    cl_fail_d  = cl_fail_q;
    cl_last_d  = cl_last_q;
    if (row_pop_o) begin
      if (closes) begin
        wrap_d     = '0;
        chk_d      = '0;
        oob_d      = 1'b0;
        caov_d     = 1'b0;
        cnt_d      = '0;
        cl_valid_d = 1'b1;
        cl_part_d  = oob_new ? chk_new : wrap_new;
        cl_fail_d  = oob_new && caov_new;
        cl_last_d  = row_i.last;
      end else begin
        wrap_d = wrap_new;
        chk_d  = chk_new;
        oob_d  = oob_new;
        caov_d = caov_new;
        cnt_d  = cnt_q + 1'b1;
      end
    end
  end

  assign fail_pre = failed_q || cl_fail_q;
  assign tot_sum  = tot_q + cl_part_q;
  assign tot_ovf  = pes_pkg::add_ovf(tot_q, cl_part_q, tot_sum);
  assign fail_new = fail_pre || tot_ovf;
  assign tot_new  = fail_new ? tot_q : tot_sum;

  always_comb begin
    tot_d       = tot_q;
    failed_d    = failed_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (cl_fire) begin
      if (cl_last_q) begin
        tot_d          = '0;
        failed_d       = 1'b0;
        out_valid_d    = 1'b1;
        out_d.sum      = fail_new ? '0 : tot_new;
        out_d.overflow = fail_new;
      end else begin
        tot_d    = tot_new;
        failed_d = fail_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q      <= '0;
      chk_q       <= '0;
      oob_q       <= 1'b0;
      caov_q      <= 1'b0;
      cnt_q       <= '0;
      cl_valid_q  <= 1'b0;
      tot_q       <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wrap_q      <= wrap_d;
      chk_q       <= chk_d;
      oob_q       <= oob_d;
      caov_q      <= caov_d;
      cnt_q       <= cnt_d;
      cl_valid_q  <= cl_valid_d;
      tot_q       <= tot_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cl_part_q <= cl_part_d;
    cl_fail_q <= cl_fail_d;
    cl_last_q <= cl_last_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: design/predicated_exact_sum_core.sv
// Conditional exact 64-bit column sum with overflow detection. One row is
// accepted per clock cycle while in_stall_o is low; the front compares the
// key against the threshold and classifies the value's bound, a two-entry
// queue decouples it from the back, where a chunk accumulator is followed by
// one grand-total adder stage. The result of the row marked last passes the
// queue and the close stage and is held in an output register. There is no
// clearing pass after reset. Registers: compare_op at byte 0, threshold at 8.
// depends on pes_pkg, pes_front, pes_queue, pes_back
module predicated_exact_sum_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pes_pkg::AddrW-1:0]  paddr,
  input  logic [pes_pkg::DataW-1:0]  pwdata,
  output logic [pes_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  pes_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output pes_pkg::out_item_t         out_data_o
);

  pes_pkg::row_t row_in, row_head;
  logic          q_full, q_valid, q_pop, q_push;

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  pes_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item_i  (in_data_i),
    .row_o   (row_in)
  );

  pes_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_row_i (row_in),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (row_head)
  );

  pes_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_valid_i (q_valid),
    .row_i       (row_head),
    .row_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_data_o)
  );

endmodule

FILE: tb/predicated_exact_sum_core_test.sv
// testbench for predicated_exact_sum_core: streams columns of rows, predicts each column
// sum and overflow flag, and checks every result as it leaves the block
// depends on pes_pkg and predicated_exact_sum_core
`timescale 1ns / 100ps

module predicated_exact_sum_core_test;

  localparam logic [2:0] CmpSpare = 3'd7;
  localparam logic [pes_pkg::AddrW-1:0] AddrCompareOp = {pes_pkg::RegCompareOp, 3'b000};
  localparam logic [pes_pkg::AddrW-1:0] AddrThreshold = {pes_pkg::RegThreshold, 3'b000};
  localparam logic [63:0] MaxVal = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
  localparam logic [63:0] BoundVal = 64'h0004_0000_0000_0000;
  localparam int ResultLatency = 3;
  localparam int QuietLimit = 4000;
  localparam int RandomRows = 1800;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [pes_pkg::AddrW-1:0] paddr = '0;
  logic [pes_pkg::DataW-1:0] pwdata = '0;
  logic [pes_pkg::DataW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  pes_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  pes_pkg::out_item_t out_data_o;

  predicated_exact_sum_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // predictor state and register copies
  logic [63:0] total_acc = '0;
  logic [63:0] chunk_wrap = '0;
  logic [63:0] chunk_checked = '0;
  bit chunk_oob = 1'b0;
  bit chunk_ovf = 1'b0;
  bit column_failed = 1'b0;
  int unsigned chunk_rows = 0;
  logic [2:0] sel_op = pes_pkg::CmpAll;
  logic signed [63:0] sel_threshold = '0;

  pes_pkg::out_item_t sums_due[$];
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit idle_en = 1'b1;

  function automatic bit add_wraps(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return ((a ^ s) & (b ^ s)) >> 63 != 0;
  endfunction

  function automatic bit row_counts(logic signed [63:0] k);
    case (sel_op)
      pes_pkg::CmpLt: return k < sel_threshold;
      pes_pkg::CmpLe: return k <= sel_threshold;
      pes_pkg::CmpGt: return k > sel_threshold;
      pes_pkg::CmpGe: return k >= sel_threshold;
      pes_pkg::CmpEq: return k == sel_threshold;
      pes_pkg::CmpNe: return k != sel_threshold;
      default: return 1'b1;
    endcase
  endfunction

  function automatic void clear_chunk_state();
    chunk_wrap = '0;
    chunk_checked = '0;
    chunk_oob = 1'b0;
    chunk_ovf = 1'b0;
    chunk_rows = 0;
  endfunction

  function automatic void fold_chunk();
    logic [63:0] part;
    if (chunk_oob) begin
      if (chunk_ovf) column_failed = 1'b1;
      part = chunk_checked;
    end else begin
      part = chunk_wrap;
    end
    if (!column_failed) begin
      if (add_wraps(total_acc, part)) column_failed = 1'b1;
      else total_acc = total_acc + part;
    end
    clear_chunk_state();
  endfunction

  function automatic bit accumulate_row(pes_pkg::in_item_t r, output pes_pkg::out_item_t res);
    logic [63:0] v;
    logic [63:0] shifted;
    v = r.value;
    res = '0;
    if (row_counts(r.key)) begin
      chunk_wrap = chunk_wrap + v;
      shifted = v + BoundVal;
      if (shifted[63:51] != 0) chunk_oob = 1'b1;
      if (!chunk_ovf) begin
        if (add_wraps(chunk_checked, v)) chunk_ovf = 1'b1;
        else chunk_checked = chunk_checked + v;
      end
    end
    chunk_rows++;
    if (r.last || chunk_rows >= pes_pkg::ChunkRows) fold_chunk();
    if (!r.last) return 1'b0;
    res.sum = column_failed ? '0 : total_acc;
    res.overflow = column_failed;
    total_acc = '0;
    column_failed = 1'b0;
    clear_chunk_state();
    return 1'b1;
  endfunction

  function automatic int pick_burst();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 60) return 0;
    return pick_burst();
  endfunction

  function automatic logic [2:0] op_by_index(int i);
    case (i)
      0: return pes_pkg::CmpLt;
      1: return pes_pkg::CmpLe;
      2: return pes_pkg::CmpGt;
      3: return pes_pkg::CmpGe;
      4: return pes_pkg::CmpEq;
      5: return pes_pkg::CmpNe;
      6: return pes_pkg::CmpAll;
      default: return CmpSpare;
    endcase
  endfunction

  function automatic logic [63:0] inbound_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return {{13{r[50]}}, r[50:0]};
  endfunction

  function automatic logic [63:0] rand_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: r = MaxVal;
          1: r = MinVal;
          2: r = '0;
          default: r = '1;
        endcase
      end
      1: begin
        case ($urandom_range(0, 3))
          0: r = BoundVal - 64'd1;
          1: r = -BoundVal;
          2: r = BoundVal;
          default: r = -BoundVal - 64'd1;
        endcase
      end
      2, 3, 4: r = inbound_value();
      5: r = MaxVal - 64'($urandom_range(0, 255));
      6: r = MinVal + 64'($urandom_range(0, 255));
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return sel_threshold + 64'($urandom_range(0, 4)) - 64'd2;
      4: return $urandom_range(0, 1) ? MaxVal : MinVal;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // receiver side stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 99) < 25) begin
      out_stall_i <= 1'b1;
      stall_left <= pick_burst() - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_sums
    pes_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sums_due.size() == 0) begin
        $display("%0t: unexpected result, sum %h overflow %b", $time,
                 out_data_o.sum, out_data_o.overflow);
        mismatch_count++;
      end else begin
        want = sums_due.pop_front();
        if (out_data_o.sum !== want.sum) begin
          $display("%0t: sum expected %h actual %h", $time, want.sum, out_data_o.sum);
          mismatch_count++;
        end
        if (out_data_o.overflow !== want.overflow) begin
          $display("%0t: overflow expected %b actual %b", $time,
                   want.overflow, out_data_o.overflow);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_row(logic [63:0] v, logic [63:0] k, bit is_last);
    pes_pkg::in_item_t r;
    pes_pkg::out_item_t res;
    int gap;
    r.value = v;
    r.key = k;
    r.last = is_last;
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    if (accumulate_row(r, res)) sums_due.push_back(res);
    gap = idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_all_sums();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sums_due.size() != 0);
  endtask

  task automatic write_reg(logic [pes_pkg::AddrW-1:0] a, logic [63:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_config(logic [2:0] op, logic [63:0] thr);
    logic [63:0] w;
    wait_all_sums();
    repeat (ResultLatency + 3) @(posedge clk_i);
    w = {$urandom, $urandom};
    w[2:0] = op;
    write_reg(AddrCompareOp, w);
    write_reg(AddrThreshold, thr);
    sel_op = op;
    sel_threshold = thr;
  endtask

  // reset values select every row
  task automatic test_reset_values();
    send_row(BoundVal - 64'd1, MaxVal, 1'b0);
    send_row(-BoundVal, MinVal, 1'b1);
    send_row(MaxVal, '0, 1'b0);
    send_row(64'd1, '0, 1'b1);
    send_row(MaxVal, '0, 1'b0);
    send_row(64'd1, '0, 1'b0);
    send_row('1, '0, 1'b1);
    send_row(MinVal, '0, 1'b1);
  endtask

  task automatic test_compare_ops();
    logic [63:0] thr;
    for (int i = 0; i < 8; i++) begin
      thr = i[0] ? MaxVal : MinVal + 64'd1;
      apply_config(op_by_index(i), thr);
      send_row(64'(i + 1) << 4, thr - 64'd1, 1'b0);
      send_row(64'd1, thr, 1'b1);
    end
  endtask

  task automatic test_random_columns();
    int rows;
    int grp;
    int len;
    bit inbound_only;
    logic [63:0] thr;
    rows = 0;
    grp = 0;
    while (rows < RandomRows) begin
      idle_en = (grp % 4 != 3);
      case ($urandom_range(0, 4))
        0: thr = MinVal;
        1: thr = MaxVal;
        2: thr = '0;
        3: thr = inbound_value();
        default: thr = {$urandom, $urandom};
      endcase
      apply_config(op_by_index(grp % 8), thr);
      for (int col = 0; col < 6; col++) begin
        if ($urandom_range(0, 19) == 0) wait_all_sums();
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 80);
        inbound_only = ($urandom_range(0, 2) == 0);
        for (int n = 0; n < len; n++)
          send_row(inbound_only ? inbound_value() : rand_value(), rand_key(), n == len - 1);
        rows += len;
      end
      grp++;
    end
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_compare_ops();
    test_random_columns();
    wait_all_sums();
    repeat (ResultLatency + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
